[rtl/fhc_pkg.sv]
// fhc_pkg: shared types and constants for the single/half float converter.
// Depends on nothing; used by float32_half_converter.
package fhc_pkg;

  // Direction command carried with each input word.
  typedef enum logic {
    CMD_NARROW = 1'b0,  // single to half
    CMD_WIDEN  = 1'b1   // half (bits 15:0) to single
  } cmd_e;

  // How the first stage classified an operand.
  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,  // magnitude fully known after decode
    KIND_SUB   = 2'd1,  // subnormal path: narrowing shift or widening normalize
    KIND_NORM  = 2'd2   // narrowing normal path: exponent plus rounded mantissa
  } kind_e;

  localparam logic [14:0] HalfExpMask   = 15'h7C00;
  localparam logic [14:0] HalfQnanBit   = 15'h0200;
  localparam logic [23:0] HalfRoundBit  = 24'h001000;
  localparam logic        SingleHidden  = 1'b1;
  localparam logic [7:0]  SingleExpMax  = 8'hFF;
  localparam logic [4:0]  HalfExpMax    = 5'h1F;
  localparam logic [7:0]  ExpBiasDiff   = 8'd112;  // 127 - 15
  localparam logic [7:0]  SubExpBase    = 8'd113;  // exponent of a widened subnormal, lz = 0
  localparam logic [7:0]  NarrowSubLow  = 8'd102;  // below this a single rounds to zero
  localparam logic [7:0]  NarrowOvfExp  = 8'd143;  // from here a single overflows to infinity
  localparam logic [7:0]  NarrowShBase  = 8'd126;  // subnormal shift = 126 - exponent

  // Stage 1 payload: decoded operand.
  typedef struct packed {
    cmd_e        cmd;
    logic        sign;
    kind_e       kind;
    logic [30:0] fixed;  // magnitude for KIND_FIXED
    logic [23:0] mant;   // narrowing: hidden bit and mantissa; widening: half mantissa
    logic [4:0]  sh;     // narrowing right shift, or widening leading-zero count
    logic [4:0]  e;      // narrowing half exponent
    logic [10:0] m;      // narrowing rounded mantissa, carry in bit 10
  } s1_t;

  // Stage 2 payload: unsigned result magnitude.
  typedef struct packed {
    cmd_e        cmd;
    logic        sign;
    logic [30:0] mag;
  } s2_t;

endpackage

[rtl/float32_half_converter.sv]
// float32_half_converter: three-stage pipelined converter between IEEE single and half.
// Depends on fhc_pkg for stage payload types and format constants.
//
// Each input word carries a direction command and a 32-bit pattern; each word yields exactly
// one output word, in order. Command 0 narrows a single to half, rounding the magnitude to
// nearest with ties away from zero; overflow gives a signed infinity, tiny values and single
// subnormals give signed zero, and any NaN gives the sign with quiet NaN 0x7E00. The half
// lands in bits 15:0 with bits 31:16 zero. Command 1 widens the half in bits 15:0 exactly to
// single, normalizing subnormals and keeping a NaN payload shifted left by 13. An accepted
// word passes through stage 1, stage 2 and the output register in order, and the block
// takes one word every cycle while in_stall_o is low: decode with leading-zero count, then
// the rounding shift and exponent merge, then sign insertion into the output register. Each
// stage advances when the stage after it is empty or moving, so in_stall_o rises only when
// all three stages hold a word and out_stall_i is high; no word is lost or repeated under
// any stall pattern.
module float32_half_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] operand_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] converted_bits_o
);

  // Pipeline control
  logic adv1, adv2, adv3;
  logic v1_q, v2_q, v3_q;

  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o  = !adv1;
  assign out_valid_o = v3_q;

  // Stage 1: classify the operand and count leading zeros of a half subnormal
  fhc_pkg::s1_t s1_d, s1_q;

  logic [7:0]  n_ex;
  logic [22:0] n_man;
  logic [4:0]  h_ex;
  logic [9:0]  h_man;
  logic [3:0]  h_lz;
  logic [23:0] n_rnd;

  assign n_ex  = operand_bits_i[30:23];
  assign n_man = operand_bits_i[22:0];
  assign h_ex  = operand_bits_i[14:10];
  assign h_man = operand_bits_i[9:0];
  assign n_rnd = {1'b0, n_man} + fhc_pkg::HalfRoundBit;

  // Shift needed to bring the top set bit of the half mantissa up to bit 10.
  always_comb begin
    h_lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) begin
        h_lz = 4'(10 - i);
      end
    end
  end

  always_comb begin
    s1_d       = '0;
    s1_d.cmd   = fhc_pkg::cmd_e'(command_i);
    s1_d.kind  = fhc_pkg::KIND_FIXED;
    if (command_i == fhc_pkg::CMD_NARROW) begin
      s1_d.sign = operand_bits_i[31];
      s1_d.mant = {fhc_pkg::SingleHidden, n_man};
      s1_d.sh   = 5'(fhc_pkg::NarrowShBase - n_ex);
      s1_d.e    = 5'(n_ex - fhc_pkg::ExpBiasDiff);
      s1_d.m    = n_rnd[23:13];
      if (n_ex == fhc_pkg::SingleExpMax) begin
        // Infinity keeps its form; any NaN collapses to the quiet pattern.
        s1_d.fixed = 31'(fhc_pkg::HalfExpMask | ((n_man != '0) ? fhc_pkg::HalfQnanBit : '0));
      end else if (n_ex < fhc_pkg::NarrowSubLow) begin
        s1_d.fixed = '0;
      end else if (n_ex <= fhc_pkg::ExpBiasDiff) begin
        s1_d.kind = fhc_pkg::KIND_SUB;
      end else if (n_ex >= fhc_pkg::NarrowOvfExp) begin
        s1_d.fixed = 31'(fhc_pkg::HalfExpMask);
      end else begin
        s1_d.kind = fhc_pkg::KIND_NORM;
      end
    end else begin
      s1_d.sign = operand_bits_i[15];
      s1_d.mant = 24'(h_man);
      s1_d.sh   = 5'(h_lz);
      if (h_ex == '0) begin
        if (h_man != '0) begin
          s1_d.kind = fhc_pkg::KIND_SUB;
        end
      end else if (h_ex == fhc_pkg::HalfExpMax) begin
        s1_d.fixed = {fhc_pkg::SingleExpMax, h_man, 13'd0};
      end else begin
        s1_d.fixed = {8'(h_ex) + fhc_pkg::ExpBiasDiff, h_man, 13'd0};
      end
    end
  end

  // Stage 2: round-and-shift the narrowing subnormal, normalize the widening one,
  // merge the narrowing normal exponent (a mantissa carry ripples into it)
  fhc_pkg::s2_t s2_d, s2_q;

  logic [24:0] sub_sum;
  logic [24:0] sub_shr;
  logic [10:0] wid_norm;
  logic [14:0] nrm_sum;

  assign sub_sum  = {1'b0, s1_q.mant} + (25'd1 << (s1_q.sh - 5'd1));
  assign sub_shr  = sub_sum >> s1_q.sh;
  assign wid_norm = 11'(s1_q.mant[9:0]) << s1_q.sh[3:0];
  assign nrm_sum  = {s1_q.e, 10'd0} + 15'(s1_q.m);

  always_comb begin
    s2_d.cmd  = s1_q.cmd;
    s2_d.sign = s1_q.sign;
    case (s1_q.kind)
      fhc_pkg::KIND_SUB: begin
        if (s1_q.cmd == fhc_pkg::CMD_NARROW) begin
          s2_d.mag = 31'(sub_shr[10:0]);
        end else begin
          s2_d.mag = {fhc_pkg::SubExpBase - 8'(s1_q.sh), wid_norm[9:0], 13'd0};
        end
      end
      fhc_pkg::KIND_NORM: s2_d.mag = 31'(nrm_sum);
      default:            s2_d.mag = s1_q.fixed;
    endcase
  end

  // Stage 3: place the sign and hold the output word
  logic [31:0] out_d, out_q;

  always_comb begin
    if (s2_q.cmd == fhc_pkg::CMD_NARROW) begin
      out_d = {16'd0, s2_q.sign, s2_q.mag[14:0]};
    end else begin
      out_d = {s2_q.sign, s2_q.mag};
    end
  end

  assign converted_bits_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Payload registers: advance only with a valid word behind them, else hold.
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) s1_q  <= s1_d;
    if (adv2 && v1_q)       s2_q  <= s2_d;
    if (adv3 && v2_q)       out_q <= out_d;
  end

  // Assertions
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled while the pipeline has a free stage");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !adv3) |=> (v2_q && $stable(s2_q)))
    else $error("stage 2 word changed while the output was blocked");

  a_narrow_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && s2_q.cmd == fhc_pkg::CMD_NARROW) |-> (s2_q.mag[30:15] == '0))
    else $error("narrowed magnitude wider than a half");

  a_sub_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && s1_q.kind == fhc_pkg::KIND_SUB && s1_q.cmd == fhc_pkg::CMD_NARROW)
      |-> (s1_q.sh >= 5'd14 && s1_q.sh <= 5'd24))
    else $error("narrowing subnormal shift out of range");

  a_sub_lz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && s1_q.kind == fhc_pkg::KIND_SUB && s1_q.cmd == fhc_pkg::CMD_WIDEN)
      |-> (s1_q.sh >= 5'd1 && s1_q.sh <= 5'd10))
    else $error("widening subnormal leading-zero count out of range");

endmodule
